// ===== src/gdd_pkg.sv =====
// Shared widths, calendar tables and pipeline control types for the date difference core.
package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int COUNT_W = 21;
    localparam int DOY_W   = 9;

    // Reciprocal constants: floor(x * K >> S) == floor(x / D) over the used range.
    localparam int REC100_K = 5243;  // x < 8192, x / 100
    localparam int REC100_S = 19;
    localparam int REC25_K  = 328;   // x < 512, x / 25
    localparam int REC25_S  = 13;

    localparam int DAYS_PER_YEAR = 365;
    localparam int MARCH         = 3;

    // Per-stage load enables of the day number pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Days in the months before month m of a common year; 0 and 13..15 saturate.
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd365;
        endcase
        return r;
    endfunction

endpackage

// ===== src/gregorian_date_difference_core.sv =====
// Top level of the Gregorian date difference core: pipeline control and final subtract.
//
// Takes a transaction every cycle while in_ready is high and returns one day_count per
// transaction, in order, from the output register of stage four. Each date
// becomes a day number (days in all prior years plus day of year, Gregorian leap rule)
// in a three-stage pipeline; stage one holds the constant reciprocal multiplies for the
// divisions by 100 and 400, stage two forms the year base and leap day, stage three
// adds them. Stage four subtracts the two day numbers, adds include_end, clamps a
// negative difference to zero and gives zero when the first date is not strictly
// earlier. Each stage has its own valid bit and loads when empty or when its content
// moves on, so a stall on out_ready fills the bubbles first and then backs up to
// in_ready without losing or repeating a transaction.
module gregorian_date_difference_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gdd_pkg::DAY_W-1:0]     first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]   first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]    first_year,
    input  logic [gdd_pkg::DAY_W-1:0]     second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]   second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]    second_year,
    input  logic                          include_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gdd_pkg::COUNT_W-1:0]   day_count
);
    import gdd_pkg::*;

    localparam int CMP_W = YEAR_W + MONTH_W + DAY_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic load1, load2, load3, load4;
    stage_en_t en;

    // side-band carried alongside the day number pipeline
    logic before1_reg, before2_reg, before3_reg;
    logic inc1_reg, inc2_reg, inc3_reg;
    logic before_next;

    logic [COUNT_W-1:0] num1, num2;
    logic [COUNT_W:0]   diff;
    logic [COUNT_W-1:0] count_reg, count_next;

    // ready ripples back from the output register
    always_comb
    begin
        load4 = !v4_reg || out_ready;
        load3 = !v3_reg || load4;
        load2 = !v2_reg || load3;
        load1 = !v1_reg || load2;
        en.s1 = load1;
        en.s2 = load2;
        en.s3 = load3;
    end

    assign in_ready  = load1;
    assign out_valid = v4_reg;
    assign day_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (load1) v1_reg <= in_valid;
            if (load2) v2_reg <= v1_reg;
            if (load3) v3_reg <= v2_reg;
            if (load4) v4_reg <= v3_reg;
        end
    end

    // year, then month, then day: one wide compare on the packed date
    assign before_next = {first_year, first_month, first_day}
                         < CMP_W'({second_year, second_month, second_day});

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            before1_reg <= before_next;
            inc1_reg    <= include_end;
        end
        if (load2)
        begin
            before2_reg <= before1_reg;
            inc2_reg    <= inc1_reg;
        end
        if (load3)
        begin
            before3_reg <= before2_reg;
            inc3_reg    <= inc2_reg;
        end
    end

    gdd_day_number u_first (
        .clk     (clk),
        .en      (en),
        .day     (first_day),
        .month   (first_month),
        .year    (first_year),
        .day_num (num1)
    );

    gdd_day_number u_second (
        .clk     (clk),
        .en      (en),
        .day     (second_day),
        .month   (second_month),
        .year    (second_year),
        .day_num (num2)
    );

    // sign bit of diff flags an out-of-range month or day giving a negative span
    always_comb
    begin
        diff = {1'b0, num2} - {1'b0, num1} + (COUNT_W+1)'(inc3_reg);
        if (before3_reg && !diff[COUNT_W])
            count_next = diff[COUNT_W-1:0];
        else
            count_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while output side is ready");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with a bubble in the pipeline");

    a_not_before_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (load4 && v3_reg && !before3_reg) |=> (day_count == '0))
        else $error("nonzero count for a start date not before the end date");

    a_out_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v3_reg))
        else $error("output valid without a transaction in stage three");
`endif

endmodule

// ===== src/gdd_day_number.sv =====
// Three-stage pipeline that turns one date into its absolute day number.
module gdd_day_number (
    input  logic                          clk,
    input  gdd_pkg::stage_en_t            en,
    input  logic [gdd_pkg::DAY_W-1:0]     day,
    input  logic [gdd_pkg::MONTH_W-1:0]   month,
    input  logic [gdd_pkg::YEAR_W-1:0]    year,
    output logic [gdd_pkg::COUNT_W-1:0]   day_num
);
    import gdd_pkg::*;

    localparam int C100_W = YEAR_W + 1;        // year + 99
    localparam int P100C_W = C100_W + 13;
    localparam int P100F_W = YEAR_W + 13;
    localparam int C400_W = YEAR_W + 1;        // year + 399
    localparam int Q16_W = C400_W - 4;
    localparam int P400_W = Q16_W + 9;
    localparam int CEIL4_W = YEAR_W - 1;

    // stage 1
    logic [YEAR_W-1:0]   year_reg;
    logic [P100C_W-1:0]  p100c_reg, p100c_next;
    logic [P100F_W-1:0]  p100f_reg, p100f_next;
    logic [P400_W-1:0]   p400_reg, p400_next;
    logic [COUNT_W-1:0]  y365_reg, y365_next;
    logic [CEIL4_W-1:0]  ceil4_reg, ceil4_next;
    logic [DOY_W-1:0]    doy_base_reg, doy_base_next;
    logic                late_reg, y4z_reg, y16z_reg;
    // stage 2
    logic [COUNT_W-1:0]  dby_reg, dby_next;
    logic [DOY_W-1:0]    doy_reg, doy_next;
    // stage 3
    logic [COUNT_W-1:0]  num_reg, num_next;

    logic [C100_W-1:0]   c100;
    logic [C400_W-1:0]   c400;
    logic [Q16_W-1:0]    q16;
    logic [6:0]          q100c;
    logic [5:0]          q100f;
    logic [4:0]          q400c;
    logic                r100z, leap;

    always_comb
    begin
        c100 = {1'b0, year} + C100_W'(99);
        c400 = {1'b0, year} + C400_W'(399);
        q16  = c400[C400_W-1:4];
        p100c_next    = P100C_W'(c100) * P100C_W'(REC100_K);
        p100f_next    = P100F_W'(year) * P100F_W'(REC100_K);
        p400_next     = P400_W'(q16) * P400_W'(REC25_K);
        y365_next     = COUNT_W'(year) * COUNT_W'(DAYS_PER_YEAR);
        ceil4_next    = CEIL4_W'((YEAR_W'(year) + YEAR_W'(3)) >> 2)
                        | (CEIL4_W'(year > YEAR_W'(4092)) << (CEIL4_W - 1));
        doy_base_next = days_before_month(month) + DOY_W'(day);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            year_reg     <= year;
            p100c_reg    <= p100c_next;
            p100f_reg    <= p100f_next;
            p400_reg     <= p400_next;
            y365_reg     <= y365_next;
            ceil4_reg    <= ceil4_next;
            doy_base_reg <= doy_base_next;
            late_reg     <= (month >= MONTH_W'(MARCH));
            y4z_reg      <= (year[1:0] == 2'd0);
            y16z_reg     <= (year[3:0] == 4'd0);
        end
    end

    // Divisible by 100 and by 16 together means divisible by 400.
    always_comb
    begin
        q100c = p100c_reg[P100C_W-1 -: 7];
        q100f = p100f_reg[P100F_W-1 -: 6];
        q400c = p400_reg[P400_W-1 -: 5];
        r100z = (year_reg == (YEAR_W'(q100f) * YEAR_W'(100)));
        leap  = y4z_reg && (!r100z || y16z_reg);
        dby_next = y365_reg + COUNT_W'(ceil4_reg) - COUNT_W'(q100c) + COUNT_W'(q400c);
        doy_next = doy_base_reg + DOY_W'(late_reg && leap);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            dby_reg <= dby_next;
            doy_reg <= doy_next;
        end
    end

    assign num_next = dby_reg + COUNT_W'(doy_reg);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            num_reg <= num_next;
        end
    end

    assign day_num = num_reg;

endmodule
